// ===== design/vbd_pkg.sv =====
// Shared types, constants and helpers of the variable-byte delta codec.
package vbd_pkg;

  // Value width of the code; results and inputs are 32 bits wide.
  localparam int VALUE_BITS  = 32;
  localparam int WIDTH       = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int GROUP_BITS  = 7;
  localparam int POS_BITS    = 3;
  localparam int POS_MAX     = (1 << POS_BITS) - 1;
  // A group placed at the highest position reaches this many bits.
  localparam int SPREAD_BITS = GROUP_BITS * (POS_MAX + 1);
  localparam int DATA_BITS   = 32;

  typedef logic [WIDTH-1:0]       value_t;
  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [SPREAD_BITS-1:0] spread_t;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 1;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t CFG_DIRECTION = 2'd0;
  localparam cfg_index_t CFG_DELTA     = 2'd1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENC_GAP,
    ST_DEC_COLLECT,
    ST_DEC_SUM,
    ST_EMIT
  } state_t;

  // Place a 7-bit group at its position in the word.
  function automatic spread_t place_group(logic [GROUP_BITS-1:0] group, pos_t pos);
    spread_t wide;
    wide = spread_t'(group);
    return wide << (GROUP_BITS * int'(pos));
  endfunction

endpackage

// ===== design/vbd_if.sv =====
// Valid/ready stream interfaces for code input items and results.
interface vbd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] item_data;
  logic        list_start;

  modport source (output valid, output item_data, output list_start, input ready);
  modport sink   (input valid, input item_data, input list_start, output ready);
endinterface

interface vbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_data;
  logic        out_last;
  logic        overflow;

  modport source (output valid, output out_data, output out_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_data, input out_last, input overflow,
                  output ready);
endinterface

// ===== design/vbd_alu.sv =====
// Shared modular adder/subtractor used for gap coding in both directions.
module vbd_alu (
  input  vbd_pkg::value_t  a,
  input  vbd_pkg::value_t  b,
  input  vbd_pkg::alu_op_t op,
  output vbd_pkg::value_t  y
);

  // Add or subtract modulo 2^WIDTH
  always_comb begin
    unique case (op)
      vbd_pkg::ALU_ADD: y = a + b;
      vbd_pkg::ALU_SUB: y = a - b;
      default:          y = a + b;
    endcase
  end

endmodule

// ===== design/vbd_decode_step.sv =====
// Collects one code byte into the partial decode word.
module vbd_decode_step (
  input  logic [7:0]      code_byte,
  input  vbd_pkg::value_t acc,
  input  vbd_pkg::pos_t   pos,
  input  logic            ovf_seen,
  output vbd_pkg::value_t acc_next,
  output vbd_pkg::pos_t   pos_next,
  output logic            ovf_next,
  output logic            terminator
);

  vbd_pkg::spread_t spread;

  // Place the group and flag any set bit that falls beyond the value width
  always_comb begin
    spread     = vbd_pkg::place_group(code_byte[vbd_pkg::GROUP_BITS-1:0], pos);
    acc_next   = acc | spread[vbd_pkg::WIDTH-1:0];
    ovf_next   = ovf_seen | (|spread[vbd_pkg::SPREAD_BITS-1:vbd_pkg::WIDTH]);
    terminator = code_byte[7];
    // Saturate the group position
    if (pos == vbd_pkg::pos_t'(vbd_pkg::POS_MAX)) begin
      pos_next = pos;
    end else begin
      pos_next = pos + vbd_pkg::pos_t'(1);
    end
  end

endmodule

// ===== design/vbd_emit.sv =====
// Formats the result word: one code byte when encoding, a value when decoding.
module vbd_emit (
  input  vbd_pkg::value_t work,
  input  logic            res_dec,
  input  logic            res_ovf,
  output logic [31:0]     out_data,
  output logic            out_last,
  output logic            overflow
);

  logic enc_last;

  // The last code byte is the one that holds all remaining bits
  always_comb begin
    enc_last = (work[vbd_pkg::WIDTH-1:vbd_pkg::GROUP_BITS] == '0);
    if (res_dec) begin
      out_data = 32'(work);
      out_last = 1'b1;
      overflow = res_ovf;
    end else begin
      out_data = {24'd0, enc_last, work[vbd_pkg::GROUP_BITS-1:0]};
      out_last = enc_last;
      overflow = 1'b0;
    end
  end

endmodule

// ===== design/vbd_top_unused_placeholder.sv =====
// Shift stage that drops the emitted code group from the work word.
module vbd_group_shift (
  input  vbd_pkg::value_t work,
  output vbd_pkg::value_t work_shifted
);

  // Advance to the next 7-bit group
  assign work_shifted = work >> vbd_pkg::GROUP_BITS;

endmodule

// ===== design/vbyte_delta_codec_unit.sv =====
// Top level of the variable-byte codec with optional delta gaps.
//
// Channels: "items" takes one input item per transfer, "results" gives one
// result per transfer. Both use valid/ready; a transfer happens at a rising
// clock edge with valid and ready high. The configuration port writes
// direction (index 0) and delta_enable (index 1); the user must do so while
// the block is idle (the block does not enforce it); other indexes are ignored.
//
// Encode: a value is accepted in idle, the shared adder forms the gap in
// the gap state, then the emit state gives one code byte per result
// transfer. Decode: a non-terminating byte passes through idle and the
// collect state; a terminating byte then goes on to the sum state, where
// the shared adder adds the previous value when delta_enable is set, and
// waits in the emit state for the result transfer. One item is worked on
// at a time; items is not ready until the sequencer is back in idle.
// Reset clears configuration, the previous value and the partial decode
// word. When the receiver stalls, the pending result holds in the work
// register and the sequencer waits in its emit state.
module vbyte_delta_codec_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  vbd_pkg::cfg_index_t          cfg_index,
  input  logic [vbd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  vbd_in_if.sink                       items,
  vbd_out_if.source                    results
);

  vbd_pkg::state_t  state;
  vbd_pkg::state_t  state_next;

  logic             direction;
  logic             delta_enable;
  vbd_pkg::value_t  item;
  vbd_pkg::value_t  prev;
  vbd_pkg::value_t  acc;
  vbd_pkg::pos_t    pos;
  logic             ovf_seen;
  vbd_pkg::value_t  work;
  logic             res_dec;
  logic             res_ovf;

  vbd_pkg::value_t  alu_a;
  vbd_pkg::value_t  alu_b;
  vbd_pkg::alu_op_t alu_op;
  vbd_pkg::value_t  alu_y;

  vbd_pkg::value_t  acc_next;
  vbd_pkg::pos_t    pos_next;
  logic             ovf_next;
  logic             terminator;
  vbd_pkg::value_t  work_shifted;

  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = items.valid && items.ready;
  assign out_xfer = results.valid && results.ready;

  // Shared adder
  vbd_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .op (alu_op),
    .y  (alu_y)
  );

  // Group collection for decode
  vbd_decode_step u_dec (
    .code_byte  (item[7:0]),
    .acc        (acc),
    .pos        (pos),
    .ovf_seen   (ovf_seen),
    .acc_next   (acc_next),
    .pos_next   (pos_next),
    .ovf_next   (ovf_next),
    .terminator (terminator)
  );

  // Result formatting
  vbd_emit u_emit (
    .work     (work),
    .res_dec  (res_dec),
    .res_ovf  (res_ovf),
    .out_data (results.out_data),
    .out_last (results.out_last),
    .overflow (results.overflow)
  );

  // Next group of the encoded word
  vbd_group_shift u_shift (
    .work         (work),
    .work_shifted (work_shifted)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      vbd_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = (direction == vbd_pkg::DIR_DECODE) ? vbd_pkg::ST_DEC_COLLECT
                                                          : vbd_pkg::ST_ENC_GAP;
        end
      end
      vbd_pkg::ST_ENC_GAP:     state_next = vbd_pkg::ST_EMIT;
      vbd_pkg::ST_DEC_COLLECT: state_next = terminator ? vbd_pkg::ST_DEC_SUM
                                                       : vbd_pkg::ST_IDLE;
      vbd_pkg::ST_DEC_SUM:     state_next = vbd_pkg::ST_EMIT;
      vbd_pkg::ST_EMIT: begin
        if (out_xfer && (res_dec || results.out_last)) begin
          state_next = vbd_pkg::ST_IDLE;
        end
      end
      default:                 state_next = vbd_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshakes and adder operands
  always_comb begin
    items.ready   = 1'b0;
    results.valid = 1'b0;
    alu_a         = item;
    alu_b         = delta_enable ? prev : '0;
    alu_op        = vbd_pkg::ALU_SUB;
    unique case (state)
      vbd_pkg::ST_IDLE:        items.ready = 1'b1;
      vbd_pkg::ST_ENC_GAP:     alu_op = vbd_pkg::ALU_SUB;
      vbd_pkg::ST_DEC_COLLECT: alu_op = vbd_pkg::ALU_ADD;
      vbd_pkg::ST_DEC_SUM: begin
        alu_a  = acc;
        alu_op = vbd_pkg::ALU_ADD;
      end
      vbd_pkg::ST_EMIT:        results.valid = 1'b1;
      default:                 items.ready = 1'b0;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vbd_pkg::ST_IDLE;
      direction    <= vbd_pkg::DIR_ENCODE;
      delta_enable <= 1'b0;
      prev         <= '0;
      acc          <= '0;
      pos          <= '0;
      ovf_seen     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          vbd_pkg::CFG_DIRECTION: direction    <= cfg_data[0];
          vbd_pkg::CFG_DELTA:     delta_enable <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        vbd_pkg::ST_IDLE: begin
          // Clear list state before a list's first item
          if (in_xfer && items.list_start) begin
            prev     <= '0;
            acc      <= '0;
            pos      <= '0;
            ovf_seen <= 1'b0;
          end
        end
        vbd_pkg::ST_ENC_GAP: prev <= item;
        vbd_pkg::ST_DEC_COLLECT: begin
          acc      <= acc_next;
          ovf_seen <= ovf_next;
          if (!terminator) begin
            pos <= pos_next;
          end
        end
        vbd_pkg::ST_DEC_SUM: begin
          prev     <= alu_y;
          acc      <= '0;
          pos      <= '0;
          ovf_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item <= items.item_data[vbd_pkg::WIDTH-1:0];
    end
    unique case (state)
      vbd_pkg::ST_ENC_GAP: begin
        work    <= alu_y;
        res_dec <= 1'b0;
        res_ovf <= 1'b0;
      end
      vbd_pkg::ST_DEC_SUM: begin
        work    <= alu_y;
        res_dec <= 1'b1;
        res_ovf <= ovf_seen;
      end
      vbd_pkg::ST_EMIT: begin
        // Drop the group just transferred
        if (out_xfer && !res_dec) begin
          work <= work_shifted;
        end
      end
      default: ;
    endcase
  end

endmodule
